// ===== sv/tpk_pkg.sv =====
// Shared types, constants and helpers of the top-K min-heap selector.
`default_nettype none

package tpk_pkg;

  // Heap geometry.
  localparam int Capacity = 64;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeepW    = 7;
  localparam int NodeW    = 32;
  localparam int ScoreW   = 64;

  // Value of keep_count after reset.
  localparam logic [KeepW-1:0] KeepReset = KeepW'(Capacity);

  // Operation carried by one input item.
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  // One heap entry as stored in the RAM.
  typedef struct packed {
    logic [NodeW-1:0]         tag;
    logic signed [ScoreW-1:0] score;
  } entry_t;

  // Input item.
  typedef struct packed {
    mode_e                    mode;
    logic [NodeW-1:0]         item_node;
    logic signed [ScoreW-1:0] item_value;
    logic [IdxW-1:0]          read_index;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                     accepted;
    logic [CntW-1:0]          entry_count;
    logic signed [ScoreW-1:0] min_value;
    logic [NodeW-1:0]         min_node;
    logic [NodeW-1:0]         slot_node;
    logic signed [ScoreW-1:0] slot_value;
    logic                     slot_valid;
  } out_item_t;

  // Signed score compare, a strictly less than b.
  function automatic logic score_lt(logic signed [ScoreW-1:0] a,
                                    logic signed [ScoreW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

// ===== sv/tpk_heap_ram.sv =====
// Heap entry storage: one write port and two registered read ports.
`default_nettype none

module tpk_heap_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tpk_pkg::IdxW-1:0]  waddr_i,
  input  tpk_pkg::entry_t           wdata_i,
  input  logic                      re_i,
  input  logic [tpk_pkg::IdxW-1:0]  raddr_a_i,
  input  logic [tpk_pkg::IdxW-1:0]  raddr_b_i,
  output tpk_pkg::entry_t           rdata_a_o,
  output tpk_pkg::entry_t           rdata_b_o
);

  tpk_pkg::entry_t mem_q [tpk_pkg::Capacity];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Both read ports; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/topk_min_heap_selector.sv =====
// Top level of the top-K selector: sequencer, datapath and result register.
//
// Keeps the K largest signed scores seen, with their tags, in a 64-entry binary
// min-heap held in a RAM with one write and two read ports. One item is worked
// on at a time and in_ready_o is low while it is in flight. Each heap level
// that a push climbs or sinks through costs one RAM read state and one
// compare-and-write state. Read, clear, no-operation and dropped pushes go
// straight to the done state. The result waits in an output register until
// taken, and the block accepts the next item in the cycle after the result is
// loaded. keep_count must be written with cfg_we_i only while the block is
// idle; the block itself does not enforce this. Values above 64 act as 64 and
// zero rejects every push.
`default_nettype none

module topk_min_heap_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tpk_pkg::KeepW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tpk_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tpk_pkg::out_item_t         out_data_o
);

  localparam int IdxW = tpk_pkg::IdxW;
  localparam int CntW = tpk_pkg::CntW;

  tpk_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [tpk_pkg::KeepW-1:0] keep_q;
  logic [IdxW-1:0]    pos_q, pos_d;
  tpk_pkg::entry_t    cur_q, cur_d;
  logic               acc_q, acc_d;
  tpk_pkg::mode_e     mode_q;
  logic [IdxW-1:0]    idx_q;
  tpk_pkg::entry_t    root_q;
  tpk_pkg::out_item_t out_q, out_d;
  logic               out_valid_q;

  logic               ram_we, ram_re;
  logic [IdxW-1:0]    ram_waddr, raddr_a, raddr_b;
  tpk_pkg::entry_t    ram_wdata, ram_a, ram_b;

  logic               in_fire, out_load;
  logic [CntW-1:0]    k_eff;
  logic               can_fill, can_repl;
  logic [IdxW-1:0]    par_idx;
  logic [IdxW+1:0]    left_w, right_w;
  logic               l_ok, r_ok, sel_l, sel_r, up_swap, dn_swap;
  logic               slot_ok;

  // Entry storage.
  tpk_heap_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Handshakes.
  assign in_ready_o  = (state_q == tpk_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == tpk_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Admission decision for a push, taken at acceptance.
  assign k_eff    = (keep_q > CntW'(tpk_pkg::Capacity)) ? CntW'(tpk_pkg::Capacity)
                                                        : CntW'(keep_q);
  assign can_fill = fill_q < k_eff;
  assign can_repl = (k_eff != '0) && (fill_q != '0) &&
                    tpk_pkg::score_lt(root_q.score, in_data_i.item_value);

  // Heap index arithmetic around the current hole.
  assign par_idx = IdxW'((pos_q - IdxW'(1)) >> 1);
  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = left_w + (IdxW+2)'(1);
  assign l_ok    = left_w < (IdxW+2)'(fill_q);
  assign r_ok    = right_w < (IdxW+2)'(fill_q);

  // Compare logic: climb test and the pick of the smaller child.
  assign up_swap = tpk_pkg::score_lt(cur_q.score, ram_a.score);
  assign sel_l   = l_ok && tpk_pkg::score_lt(ram_a.score, cur_q.score);
  assign sel_r   = r_ok && (sel_l ? tpk_pkg::score_lt(ram_b.score, ram_a.score)
                                  : tpk_pkg::score_lt(ram_b.score, cur_q.score));
  assign dn_swap = sel_l || sel_r;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpk_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.mode)
            tpk_pkg::MODE_PUSH: begin
              priority if (can_fill) state_d = tpk_pkg::ST_UP_RD;
              else if (can_repl)     state_d = tpk_pkg::ST_DN_RD;
              else                   state_d = tpk_pkg::ST_DONE;
            end
            tpk_pkg::MODE_READ,
            tpk_pkg::MODE_CLEAR,
            tpk_pkg::MODE_NOP: state_d = tpk_pkg::ST_DONE;
          endcase
        end
      end
      tpk_pkg::ST_UP_RD:  state_d = (pos_q == '0) ? tpk_pkg::ST_DONE : tpk_pkg::ST_UP_CMP;
      tpk_pkg::ST_UP_CMP: state_d = up_swap ? tpk_pkg::ST_UP_RD : tpk_pkg::ST_DONE;
      tpk_pkg::ST_DN_RD:  state_d = tpk_pkg::ST_DN_CMP;
      tpk_pkg::ST_DN_CMP: state_d = dn_swap ? tpk_pkg::ST_DN_RD : tpk_pkg::ST_DONE;
      tpk_pkg::ST_DONE:   state_d = out_load ? tpk_pkg::ST_IDLE : tpk_pkg::ST_DONE;
      default:            state_d = tpk_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control per state. The moving entry stays in cur_q and
  // the hole at pos_q is filled only once its final place is known.
  always_comb begin
    fill_d    = fill_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    acc_d     = acc_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = cur_q;
    ram_re    = 1'b0;
    raddr_a   = par_idx;
    raddr_b   = right_w[IdxW-1:0];
    unique case (state_q)
      tpk_pkg::ST_IDLE: begin
        if (in_fire) begin
          cur_d = '{tag: in_data_i.item_node, score: in_data_i.item_value};
          acc_d = 1'b0;
          unique case (in_data_i.mode)
            tpk_pkg::MODE_PUSH: begin
              priority if (can_fill) begin
                pos_d  = fill_q[IdxW-1:0];
                fill_d = fill_q + CntW'(1);
                acc_d  = 1'b1;
              end else if (can_repl) begin
                pos_d = '0;
                acc_d = 1'b1;
              end else begin
                acc_d = 1'b0;
              end
            end
            tpk_pkg::MODE_READ: begin
              ram_re  = 1'b1;
              raddr_a = in_data_i.read_index;
            end
            tpk_pkg::MODE_CLEAR: fill_d = '0;
            tpk_pkg::MODE_NOP:   fill_d = fill_q;
          endcase
        end
      end
      tpk_pkg::ST_UP_RD: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      tpk_pkg::ST_UP_CMP: begin
        ram_we = 1'b1;
        if (up_swap) begin
          ram_wdata = ram_a;
          pos_d     = par_idx;
        end
      end
      tpk_pkg::ST_DN_RD: begin
        ram_re  = 1'b1;
        raddr_a = left_w[IdxW-1:0];
      end
      tpk_pkg::ST_DN_CMP: begin
        ram_we = 1'b1;
        priority if (sel_r) begin
          ram_wdata = ram_b;
          pos_d     = right_w[IdxW-1:0];
        end else if (sel_l) begin
          ram_wdata = ram_a;
          pos_d     = left_w[IdxW-1:0];
        end else begin
          ram_wdata = cur_q;
        end
      end
      tpk_pkg::ST_DONE: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result item, built from the state left behind by the item.
  assign slot_ok = (mode_q == tpk_pkg::MODE_READ) && (CntW'(idx_q) < fill_q);

  always_comb begin
    out_d.accepted    = acc_q;
    out_d.entry_count = fill_q;
    out_d.min_value   = (fill_q != '0) ? root_q.score : '0;
    out_d.min_node    = (fill_q != '0) ? root_q.tag : '0;
    out_d.slot_valid  = slot_ok;
    out_d.slot_node   = slot_ok ? ram_a.tag : '0;
    out_d.slot_value  = slot_ok ? ram_a.score : '0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpk_pkg::ST_IDLE;
      fill_q      <= '0;
      keep_q      <= tpk_pkg::KeepReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; the root copy follows every write to slot zero.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    acc_q <= acc_d;
    if (in_fire) begin
      mode_q <= in_data_i.mode;
      idx_q  <= in_data_i.read_index;
    end
    if (ram_we && (ram_waddr == '0)) begin
      root_q <= ram_wdata;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // The fill count never exceeds the heap size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(tpk_pkg::Capacity))
    else $error("heap fill count above capacity");

  // The fill count only grows by one or drops to zero on a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ((fill_q == $past(fill_q) + CntW'(1)) || (fill_q == '0)))
    else $error("heap fill count moved by an unexpected step");

  // While sinking, the hole stays inside the occupied part of the heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpk_pkg::ST_DN_CMP) |-> (CntW'(pos_q) < fill_q))
    else $error("sift-down position outside the heap");

  // An accepted push always leaves at least one entry behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |-> (out_data_o.entry_count != '0))
    else $error("accepted push reported with an empty heap");

  // The RAM is written only by the sift states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tpk_pkg::ST_IDLE) || (state_q == tpk_pkg::ST_DONE)) |-> !ram_we)
    else $error("heap write outside a sift");

endmodule

`default_nettype wire
